### design/program_flow_signature_monitor_top_assert.svh
// Assertion macros used by the program flow monitor core.
`ifndef PROGRAM_FLOW_SIGNATURE_MONITOR_TOP_ASSERT_SVH
`define PROGRAM_FLOW_SIGNATURE_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfsm assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfsm assertion failed");

`endif

### design/pfsm_pkg.sv
// Package with the types, action codes and constants of the program flow monitor.
`timescale 1ns / 1ps
package pfsm_pkg;

	localparam int SIG_W     = 32;
	localparam int ID_W      = 8;
	localparam int CNT_W     = 32;
	localparam int TIME_W    = 32;
	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [ACT_W-1:0] ACT_CHECKPOINT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_VERIFY     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RESET      = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TICK       = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RECENT     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SEED     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 1'd1;

	localparam logic [SIG_W-1:0] GOLDEN_MUL = 32'h9E37_79B9;
	localparam logic [SIG_W-1:0] SEED_RESET = '0;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [ID_W-1:0]   checkpoint_id;
		logic [TIME_W-1:0] timeout_ticks;
		logic [SIG_W-1:0]  id_mix;
	} item_t;

	typedef struct packed {
		logic [SIG_W-1:0] seed;
		logic [SIG_W-1:0] expected;
	} cfg_t;

endpackage

### design/pfsm_item_if.sv
// Input channel carrying one monitor action word.
`timescale 1ns / 1ps
interface pfsm_item_if;
	import pfsm_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [ID_W-1:0]   checkpoint_id;
	logic [TIME_W-1:0] timeout_ticks;

	modport source (output valid, action, checkpoint_id, timeout_ticks, input ready);
	modport sink (input valid, action, checkpoint_id, timeout_ticks, output ready);
endinterface

### design/pfsm_result_if.sv
// Output channel carrying one monitor result word.
`timescale 1ns / 1ps
interface pfsm_result_if;
	import pfsm_pkg::*;

	logic             valid;
	logic             ready;
	logic             pass;
	logic [SIG_W-1:0] signature_out;
	logic             sequence_complete_out;
	logic             error_out;
	logic [CNT_W-1:0] hit_count_out;

	modport source (output valid, pass, signature_out, sequence_complete_out, error_out,
		hit_count_out, input ready);
	modport sink (input valid, pass, signature_out, sequence_complete_out, error_out,
		hit_count_out, output ready);
endinterface

### design/pfsm_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface pfsm_cfg_if;
	import pfsm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/pfsm_cfg_regs.sv
// Configuration registers: signature seed and expected signature.
`timescale 1ns / 1ps
module pfsm_cfg_regs
	import pfsm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	pfsm_cfg_if.sink cfg,
	output cfg_t   regs
);

	logic [SIG_W-1:0] seed_q;
	logic [SIG_W-1:0] expected_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= SEED_RESET;
			expected_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SEED:     seed_q     <= cfg.data;
				REG_EXPECTED: expected_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign regs.seed     = seed_q;
	assign regs.expected = expected_q;

endmodule

### design/pfsm_in_stage.sv
// Input register stage; also forms the checkpoint id mixing product.
`timescale 1ns / 1ps
module pfsm_in_stage
	import pfsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pfsm_item_if.sink item,
	input  logic      take,
	output logic      valid_s1,
	output item_t     item_s1
);

	logic [SIG_W-1:0] mix_lo;
	logic             accept;

	assign item.ready = !valid_s1 || take;
	assign accept     = item.valid && item.ready;

	// The product is taken mod 2^32, so it is formed at word width only.
	assign mix_lo = {{(SIG_W-ID_W){1'b0}}, item.checkpoint_id} * GOLDEN_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action        <= item.action;
			item_s1.checkpoint_id <= item.checkpoint_id;
			item_s1.timeout_ticks <= item.timeout_ticks;
			item_s1.id_mix        <= mix_lo;
		end
	end

endmodule

### design/pfsm_core.sv
// Monitor state, per-action update logic and the result register.
`timescale 1ns / 1ps
`include "program_flow_signature_monitor_top_assert.svh"
module pfsm_core
	import pfsm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          regs,
	input  logic          valid_s1,
	input  item_t         item_s1,
	output logic          take,
	pfsm_result_if.source result
);

	logic [SIG_W-1:0]  sig_q,  sig_n;
	logic [CNT_W-1:0]  hit_q,  hit_n;
	logic [ID_W-1:0]   last_id_q, last_id_n;
	logic [TIME_W-1:0] last_time_q, last_time_n;
	logic [TIME_W-1:0] time_q, time_n;
	logic              cmpl_q, cmpl_n;
	logic              err_q,  err_n;
	logic              pass_n;
	logic              out_valid_q;
	logic [SIG_W-1:0]  folded;
	logic [TIME_W-1:0] elapsed;
	logic              exp_set;
	logic              verify_fail;

	assign take    = valid_s1 && (!out_valid_q || result.ready);
	assign exp_set = regs.expected != '0;
	assign folded  = {sig_q[SIG_W-2:0], sig_q[SIG_W-1]} ^ item_s1.id_mix;
	assign elapsed = time_q - last_time_q;
	assign verify_fail = (exp_set && (sig_q != regs.expected)) || (hit_q == '0);

	always_comb begin
		sig_n       = sig_q;
		hit_n       = hit_q;
		last_id_n   = last_id_q;
		last_time_n = last_time_q;
		time_n      = time_q;
		cmpl_n      = cmpl_q;
		err_n       = err_q;
		pass_n      = 1'b0;
		unique case (item_s1.action)
			ACT_CHECKPOINT: begin
				sig_n       = folded;
				last_id_n   = item_s1.checkpoint_id;
				last_time_n = time_q;
				hit_n       = hit_q + 1'b1;
				if (exp_set && (folded == regs.expected)) begin
					cmpl_n = 1'b1;
				end
			end
			ACT_VERIFY: begin
				if (verify_fail) begin
					err_n = 1'b1;
				end else begin
					hit_n  = '0;
					pass_n = 1'b1;
				end
			end
			ACT_RESET: begin
				sig_n     = regs.seed;
				hit_n     = '0;
				last_id_n = '0;
				cmpl_n    = 1'b0;
				err_n     = 1'b0;
			end
			ACT_TICK: begin
				time_n = time_q + 1'b1;
			end
			ACT_RECENT: begin
				pass_n = (last_id_q == item_s1.checkpoint_id) &&
					(elapsed <= item_s1.timeout_ticks);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q       <= SEED_RESET;
			hit_q       <= '0;
			last_id_q   <= '0;
			last_time_q <= '0;
			time_q      <= '0;
			cmpl_q      <= 1'b0;
			err_q       <= 1'b0;
		end else if (take) begin
			sig_q       <= sig_n;
			hit_q       <= hit_n;
			last_id_q   <= last_id_n;
			last_time_q <= last_time_n;
			time_q      <= time_n;
			cmpl_q      <= cmpl_n;
			err_q       <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The result word shows the state as it stands after the action.
	always_ff @(posedge clk) begin
		if (take) begin
			result.pass                  <= pass_n;
			result.signature_out         <= sig_n;
			result.sequence_complete_out <= cmpl_n;
			result.error_out             <= err_n;
			result.hit_count_out         <= hit_n;
		end
	end

	assign result.valid = out_valid_q;

	`PFSM_ASSERT_NEXT(a_reset_clears, clk, arst_n, take && (item_s1.action == ACT_RESET),
		(hit_q == '0) && !err_q && !cmpl_q && (last_id_q == '0))
	`PFSM_ASSERT_NOW(a_err_from_verify, clk, arst_n, $rose(err_q),
		$past(take && (item_s1.action == ACT_VERIFY)))
	`PFSM_ASSERT_NEXT(a_time_only_tick, clk, arst_n, !(take && (item_s1.action == ACT_TICK)),
		$stable(time_q))
	`PFSM_ASSERT_NOW(a_result_from_take, clk, arst_n, $rose(out_valid_q), $past(take))

endmodule

### design/program_flow_signature_monitor_top.sv
// Top level of the program flow signature monitor.
`timescale 1ns / 1ps
// The monitor takes one action word per clock while results are taken, and
// returns exactly one result word for each, in order. A result word becomes
// valid once its action has been loaded into the input register and the core
// has carried the state update into the result register. The signature fold,
// counters and flags update combinationally in the core stage, so actions
// stream at one per clock while the result side takes words; a stalled result
// holds back the input register and then the input channel. Configuration
// writes are always accepted; a new seed takes effect at the next reset
// action.
module program_flow_signature_monitor_top
	import pfsm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pfsm_cfg_if.sink      cfg,
	pfsm_item_if.sink     item,
	pfsm_result_if.source result
);

	cfg_t  regs;
	logic  valid_s1;
	item_t item_s1;
	logic  take;

	pfsm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pfsm_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pfsm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.result   (result)
	);

endmodule
